// ===== design/rcf_pkg.sv =====
package rcf_pkg;

  localparam int MaxWidth = 2048;
  localparam int ColW     = $clog2(MaxWidth);
  localparam int RowW     = 16;
  localparam int SizeW    = 12;
  localparam int PixW     = 24;
  localparam int SumW     = 13;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;

  typedef logic [PixW-1:0] pix_t;
  typedef logic signed [SumW-1:0] sum_t;

  typedef enum logic [1:0] {
    ModeEdge    = 2'd0,
    ModeSharpen = 2'd1,
    ModeBox     = 2'd2,
    ModeGauss   = 2'd3
  } filt_mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgMode   = 3'd0,
    CfgWidth  = 3'd1,
    CfgHeight = 3'd2,
    CfgXStart = 3'd3,
    CfgXEnd   = 3'd4,
    CfgYStart = 3'd5,
    CfgYEnd   = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
    logic       frame_start;
  } rcf_in_t;

  typedef struct packed {
    logic [RowW-1:0] out_row;
    logic [ColW-1:0] out_col;
    logic [7:0]      out_red;
    logic [7:0]      out_green;
    logic [7:0]      out_blue;
    logic            last_of_run;
  } rcf_out_t;

  // Item after acceptance, while the line store read is in flight
  typedef struct packed {
    pix_t            px;
    logic [RowW-1:0] row;
    logic [ColW-1:0] col;
    logic            do_filt;
    logic            do_pass;
    logic            fwd;
    pix_t            fwd_old;
    pix_t            fwd_new;
  } rcf_sa_t;

  // Item after the kernel sums
  typedef struct packed {
    sum_t            sum_r;
    sum_t            sum_g;
    sum_t            sum_b;
    pix_t            px;
    logic [RowW-1:0] row;
    logic [ColW-1:0] col;
    logic            do_filt;
    logic            do_pass;
  } rcf_sb_t;

endpackage

// ===== design/rcf_line_ram.sv =====
module rcf_line_ram #(
  parameter int Width = 48,
  parameter int Depth = 2048,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read-first: a read at the written address returns the old entry
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// ===== design/rcf_window.sv =====
module rcf_window import rcf_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  filt_mode_e    mode_i,
  input  logic          a_valid_i,
  input  rcf_sa_t       a_i,
  input  logic [2*PixW-1:0] rdata_i,
  input  logic          b_ready_i,
  output logic          a_ready_o,
  output pix_t          st_old_o,
  output logic          b_valid_o,
  output rcf_sb_t       b_o
);

  pix_t             win_q [6];
  pix_t             win   [9];
  pix_t             s_old;
  pix_t             s_new;
  logic [8:0][7:0]  ch_r;
  logic [8:0][7:0]  ch_g;
  logic [8:0][7:0]  ch_b;
  logic             a_adv;
  logic             b_valid_q;
  rcf_sb_t          b_q;
  rcf_sb_t          b_d;

  function automatic sum_t conv_sum(filt_mode_e mode, logic [8:0][7:0] a);
    sum_t corner;
    sum_t edges;
    sum_t center;
    sum_t s;
    begin
      corner = signed'({5'd0, a[0]} + {5'd0, a[2]} + {5'd0, a[6]} + {5'd0, a[8]});
      edges  = signed'({5'd0, a[1]} + {5'd0, a[3]} + {5'd0, a[5]} + {5'd0, a[7]});
      center = signed'({5'd0, a[4]});
      case (mode)
        ModeEdge:    s = (center <<< 3) - corner - edges;
        ModeSharpen: s = (center <<< 2) + center - edges;
        ModeBox:     s = corner + edges + center;
        ModeGauss:   s = corner + (edges <<< 1) + (center <<< 2);
        default:     s = '0;
      endcase
      return s;
    end
  endfunction

  assign a_ready_o = !b_valid_q || b_ready_i;
  assign a_adv     = a_valid_i && a_ready_o;

  // take the entry written by the item ahead when it hit the same column
  assign s_old    = a_i.fwd ? a_i.fwd_old : rdata_i[2*PixW-1:PixW];
  assign s_new    = a_i.fwd ? a_i.fwd_new : rdata_i[PixW-1:0];
  assign st_old_o = s_new;

  always_comb begin
    win[0] = win_q[0];
    win[1] = win_q[1];
    win[2] = s_old;
    win[3] = win_q[2];
    win[4] = win_q[3];
    win[5] = s_new;
    win[6] = win_q[4];
    win[7] = win_q[5];
    win[8] = a_i.px;
    for (int k = 0; k < 9; k++) begin
      ch_r[k] = win[k][23:16];
      ch_g[k] = win[k][15:8];
      ch_b[k] = win[k][7:0];
    end
    b_d.sum_r   = conv_sum(mode_i, ch_r);
    b_d.sum_g   = conv_sum(mode_i, ch_g);
    b_d.sum_b   = conv_sum(mode_i, ch_b);
    b_d.px      = a_i.px;
    b_d.row     = a_i.row;
    b_d.col     = a_i.col;
    b_d.do_filt = a_i.do_filt;
    b_d.do_pass = a_i.do_pass;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 6; k++) begin
        win_q[k] <= '0;
      end
      b_valid_q <= 1'b0;
    end else begin
      if (a_adv) begin
        win_q[0] <= win_q[1];
        win_q[1] <= s_old;
        win_q[2] <= win_q[3];
        win_q[3] <= s_new;
        win_q[4] <= win_q[5];
        win_q[5] <= a_i.px;
        b_valid_q <= 1'b1;
      end else if (b_ready_i) begin
        b_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_adv) begin
      b_q <= b_d;
    end
  end

  assign b_valid_o = b_valid_q;
  assign b_o       = b_q;

endmodule

// ===== design/rcf_out.sv =====
module rcf_out import rcf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  filt_mode_e mode_i,
  input  logic       b_valid_i,
  input  rcf_sb_t    b_i,
  output logic       b_ready_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output rcf_out_t   out_data_o
);

  logic     v0_q;
  logic     v1_q;
  rcf_out_t slot0_q;
  rcf_out_t slot1_q;
  rcf_out_t res_filt;
  rcf_out_t res_pass;
  logic     out_xfer;
  logic     b_adv;

  function automatic logic [7:0] div_clamp(filt_mode_e mode, sum_t s);
    logic [23:0] prod;
    sum_t        q;
    logic [7:0]  r;
    begin
      // sum / 9 for sums below 4096 by reciprocal 3641 / 2^15
      prod = {12'd0, s[11:0]} * 24'd3641;
      case (mode)
        ModeBox:   q = signed'({4'd0, prod[23:15]});
        ModeGauss: q = s >>> 4;
        default:   q = s;
      endcase
      if (q < 0) begin
        r = 8'd0;
      end else if (q > 13'sd255) begin
        r = 8'hFF;
      end else begin
        r = q[7:0];
      end
      return r;
    end
  endfunction

  always_comb begin
    res_filt.out_row     = b_i.row - 16'd1;
    res_filt.out_col     = b_i.col - 11'd1;
    res_filt.out_red     = div_clamp(mode_i, b_i.sum_r);
    res_filt.out_green   = div_clamp(mode_i, b_i.sum_g);
    res_filt.out_blue    = div_clamp(mode_i, b_i.sum_b);
    res_filt.last_of_run = !b_i.do_pass;

    res_pass.out_row     = b_i.row;
    res_pass.out_col     = b_i.col;
    res_pass.out_red     = b_i.px[23:16];
    res_pass.out_green   = b_i.px[15:8];
    res_pass.out_blue    = b_i.px[7:0];
    res_pass.last_of_run = 1'b1;
  end

  assign out_xfer  = v0_q && !out_stall_i;
  assign b_ready_o = !v0_q || (out_xfer && !v1_q);
  assign b_adv     = b_valid_i && b_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
    end else if (b_adv) begin
      v0_q <= b_i.do_filt || b_i.do_pass;
      v1_q <= b_i.do_filt && b_i.do_pass;
    end else if (out_xfer) begin
      // advance the second result into the output slot
      v0_q <= v1_q;
      v1_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_adv) begin
      slot0_q <= b_i.do_filt ? res_filt : res_pass;
      slot1_q <= res_pass;
    end else if (out_xfer && v1_q) begin
      slot0_q <= slot1_q;
    end
  end

  assign out_valid_o = v0_q;
  assign out_data_o  = slot0_q;

endmodule

// ===== design/rgb_3x3_convolution_filter_core.sv =====
// RGB 3x3 convolution filter.
// Pixels enter in raster order on the input channel (in_valid_i / in_stall_o);
// frame_start on a pixel restarts the row and column counters at 0,0.
// Results leave on the output channel (out_valid_o / out_stall_i), each with
// its row and column; last_of_run marks the final result caused by one pixel.
// Border pixels and pixels outside the selection pass through unchanged; an
// interior selected pixel is filtered and leaves when its lower-right
// neighbor arrives, ahead of that neighbor's own pass-through result.
// A result is registered after acceptance, after the kernel sums and after
// divide/clamp into the output slot. Throughput: one pixel per cycle while
// the output is not stalled; a pixel that causes two results stalls the
// input while the output, moving one result per cycle, sends the second. A
// stalled output keeps its result; the pipeline behind it fills, then
// in_stall_o rises. Registers are written over the cfg channel, always ready;
// the user must write them only while the pipeline is empty (not enforced).
// Reset clears counters, window and pipeline; line stores need no clearing.
module rgb_3x3_convolution_filter_core import rcf_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  rcf_in_t             in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output rcf_out_t            out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  filt_mode_e       mode_q;
  logic [SizeW-1:0] width_q;
  logic [RowW-1:0]  height_q;
  logic [SizeW-1:0] xs_q;
  logic [SizeW-1:0] xe_q;
  logic [RowW-1:0]  ys_q;
  logic [RowW-1:0]  ye_q;

  logic [RowW-1:0]  row_q, row_d;
  logic [ColW-1:0]  col_q, col_d;
  logic [SizeW-1:0] w_eff;
  logic [RowW-1:0]  h_eff;
  logic [ColW-1:0]  col_base, c_cur;
  logic [RowW-1:0]  r_cur;
  logic [SizeW-1:0] c_inc;
  logic [RowW:0]    r_inc;

  logic             va_q;
  rcf_sa_t          sa_q, sa_d;
  logic             a_ready;
  logic             a_adv;
  logic             in_acc;
  pix_t             st_old;
  logic [2*PixW-1:0] rdata;
  logic             b_valid;
  rcf_sb_t          sb;
  logic             b_ready;

  function automatic logic in_sel(logic [RowW-1:0] r, logic [ColW-1:0] c,
                                  logic [RowW-1:0] ys, logic [RowW-1:0] ye,
                                  logic [SizeW-1:0] xs, logic [SizeW-1:0] xe);
    return (r >= ys) && (r < ye) && ({1'b0, c} >= xs) && ({1'b0, c} < xe);
  endfunction

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= ModeEdge;
      width_q  <= SizeW'(MaxWidth);
      height_q <= 16'd1080;
      xs_q     <= '0;
      xe_q     <= SizeW'(MaxWidth);
      ys_q     <= '0;
      ye_q     <= 16'd1080;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_index_i))
        CfgMode:   mode_q   <= filt_mode_e'(cfg_data_i[1:0]);
        CfgWidth:  width_q  <= cfg_data_i[SizeW-1:0];
        CfgHeight: height_q <= cfg_data_i;
        CfgXStart: xs_q     <= cfg_data_i[SizeW-1:0];
        CfgXEnd:   xe_q     <= cfg_data_i[SizeW-1:0];
        CfgYStart: ys_q     <= cfg_data_i;
        CfgYEnd:   ye_q     <= cfg_data_i;
        default:   ;
      endcase
    end
  end

  // position of the arriving pixel and the counters after it
  always_comb begin
    if (width_q == '0) begin
      w_eff = SizeW'(1);
    end else if (width_q > SizeW'(MaxWidth)) begin
      w_eff = SizeW'(MaxWidth);
    end else begin
      w_eff = width_q;
    end
    h_eff    = (height_q == '0) ? 16'd1 : height_q;
    col_base = in_data_i.frame_start ? '0 : col_q;
    r_cur    = in_data_i.frame_start ? '0 : row_q;
    c_cur    = ({1'b0, col_base} >= w_eff) ? '0 : col_base;
    c_inc    = {1'b0, c_cur} + 12'd1;
    r_inc    = {1'b0, r_cur} + 17'd1;
    if (c_inc >= w_eff) begin
      col_d = '0;
      row_d = (r_inc >= {1'b0, h_eff}) ? '0 : r_inc[RowW-1:0];
    end else begin
      col_d = c_inc[ColW-1:0];
      row_d = (r_cur >= h_eff) ? '0 : r_cur;
    end
  end

  always_comb begin
    sa_d.px      = {in_data_i.in_red, in_data_i.in_green, in_data_i.in_blue};
    sa_d.row     = r_cur;
    sa_d.col     = c_cur;
    sa_d.do_filt = (r_cur >= 16'd2) && (c_cur >= 11'd2) && (r_cur < h_eff) &&
                   in_sel(r_cur - 16'd1, c_cur - 11'd1, ys_q, ye_q, xs_q, xe_q);
    sa_d.do_pass = (r_cur == '0) || (c_cur == '0) || (r_cur >= h_eff - 16'd1) ||
                   ({1'b0, c_cur} >= w_eff - 12'd1) ||
                   !in_sel(r_cur, c_cur, ys_q, ye_q, xs_q, xe_q);
    // the item ahead writes this column at the same edge as this read
    sa_d.fwd     = a_adv && (sa_q.col == c_cur);
    sa_d.fwd_old = st_old;
    sa_d.fwd_new = sa_q.px;
  end

  assign a_adv      = va_q && a_ready;
  assign in_stall_o = va_q && !a_ready;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
      va_q  <= 1'b0;
    end else if (in_acc) begin
      row_q <= row_d;
      col_q <= col_d;
      va_q  <= 1'b1;
    end else if (a_adv) begin
      va_q  <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      sa_q <= sa_d;
    end
  end

  rcf_line_ram #(
    .Width (2 * PixW),
    .Depth (MaxWidth)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (a_adv),
    .waddr_i (sa_q.col),
    .wdata_i ({st_old, sa_q.px}),
    .re_i    (in_acc),
    .raddr_i (c_cur),
    .rdata_o (rdata)
  );

  rcf_window u_window (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .mode_i    (mode_q),
    .a_valid_i (va_q),
    .a_i       (sa_q),
    .rdata_i   (rdata),
    .b_ready_i (b_ready),
    .a_ready_o (a_ready),
    .st_old_o  (st_old),
    .b_valid_o (b_valid),
    .b_o       (sb)
  );

  rcf_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mode_i      (mode_q),
    .b_valid_i   (b_valid),
    .b_i         (sb),
    .b_ready_o   (b_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== sim/rgb_3x3_convolution_filter_core_tb.sv =====
module rgb_3x3_convolution_filter_core_tb;
  import rcf_pkg::*;

  localparam int QuietLimit   = 2000;
  localparam int SettleCycles = 12;
  localparam int RandomPixels = 700;

  // Line-buffered 3x3 filter predictor with the queue of pixels it expects out.
  class conv_scoreboard;
    filt_mode_e      mode;
    logic [11:0]     width_r;
    logic [15:0]     height_r;
    logic [11:0]     xs, xe;
    logic [15:0]     ys, ye;
    pix_t            older [MaxWidth];
    pix_t            newer [MaxWidth];
    pix_t            win [6];
    int unsigned     row_cnt, col_cnt;
    rcf_out_t        expected_px [$];
    int              errors;

    function new();
      mode     = ModeEdge;
      width_r  = 12'd2048;
      height_r = 16'd1080;
      xs       = '0;
      xe       = 12'd2048;
      ys       = '0;
      ye       = 16'd1080;
      foreach (older[i]) begin
        older[i] = '0;
        newer[i] = '0;
      end
      foreach (win[i]) win[i] = '0;
      row_cnt = 0;
      col_cnt = 0;
      errors  = 0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [15:0] v);
      case (idx)
        CfgMode:   mode = filt_mode_e'(v[1:0]);
        CfgWidth:  width_r = v[11:0];
        CfgHeight: height_r = v;
        CfgXStart: xs = v[11:0];
        CfgXEnd:   xe = v[11:0];
        CfgYStart: ys = v;
        CfgYEnd:   ye = v;
        default: ;
      endcase
    endfunction

    function int unsigned eff_width();
      if (width_r == 0) return 1;
      if (width_r > MaxWidth) return MaxWidth;
      return 32'(width_r);
    endfunction

    function int unsigned eff_height();
      return (height_r == 0) ? 1 : height_r;
    endfunction

    function bit in_sel(int unsigned r, int unsigned c);
      return r >= ys && r < ye && c >= xs && c < xe;
    endfunction

    function int tap(int k);
      case (mode)
        ModeEdge:    return (k == 4) ? 8 : -1;
        ModeSharpen: return (k == 4) ? 5 : (k % 2 == 1) ? -1 : 0;
        ModeBox:     return 1;
        default:     return (k == 4) ? 4 : (k % 2 == 1) ? 2 : 1;
      endcase
    endfunction

    function logic [7:0] clamp8(int v);
      if (v > 255) return 8'hFF;
      if (v < 0) return 8'h00;
      return v[7:0];
    endfunction

    function void push_result(int unsigned r, int unsigned c, pix_t px);
      rcf_out_t o;
      o.out_row     = RowW'(r);
      o.out_col     = ColW'(c);
      o.out_red     = px[23:16];
      o.out_green   = px[15:8];
      o.out_blue    = px[7:0];
      o.last_of_run = 1'b0;
      expected_px.push_back(o);
    endfunction

    function void take_pixel(rcf_in_t p);
      int unsigned w, h, r, c;
      int          sum, sh, k, d, n;
      pix_t        px, s_old, s_new, filt;
      pix_t        nb [9];
      w = eff_width();
      h = eff_height();
      if (p.frame_start) begin
        row_cnt = 0;
        col_cnt = 0;
      end
      if (col_cnt >= w) col_cnt = 0;
      r = row_cnt;
      c = col_cnt;
      px = {p.in_red, p.in_green, p.in_blue};
      s_old = older[c];
      s_new = newer[c];
      nb = '{win[0], win[1], s_old, win[2], win[3], s_new, win[4], win[5], px};
      n = 0;
      // the arriving pixel completes the window of its upper-left neighbor
      if (r >= 2 && c >= 2 && r - 1 < h - 1 && c - 1 < w - 1 && in_sel(r - 1, c - 1)) begin
        d = (mode == ModeBox) ? 9 : (mode == ModeGauss) ? 16 : 1;
        for (sh = 0; sh <= 16; sh += 8) begin
          sum = 0;
          for (k = 0; k < 9; k++) sum += tap(k) * int'(nb[k][sh +: 8]);
          filt[sh +: 8] = clamp8(sum / d);
        end
        push_result(r - 1, c - 1, filt);
        n++;
      end
      if (r == 0 || c == 0 || r >= h - 1 || c >= w - 1 || !in_sel(r, c)) begin
        push_result(r, c, px);
        n++;
      end
      if (n > 0) expected_px[expected_px.size() - 1].last_of_run = 1'b1;

      older[c] = s_new;
      newer[c] = px;
      win[0] = win[1];
      win[1] = s_old;
      win[2] = win[3];
      win[3] = s_new;
      win[4] = win[5];
      win[5] = px;

      col_cnt = c + 1;
      if (col_cnt >= w) begin
        col_cnt = 0;
        row_cnt = r + 1;
        if (row_cnt >= h) row_cnt = 0;
      end else if (r >= h) begin
        row_cnt = 0;
      end
    endfunction

    function void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(rcf_out_t got);
      rcf_out_t want;
      if (expected_px.size() == 0) begin
        $error("result for row %0d col %0d with nothing expected", got.out_row, got.out_col);
        errors++;
        return;
      end
      want = expected_px.pop_front();
      check_field("out_row", 32'(want.out_row), 32'(got.out_row));
      check_field("out_col", 32'(want.out_col), 32'(got.out_col));
      check_field("out_red", 32'(want.out_red), 32'(got.out_red));
      check_field("out_green", 32'(want.out_green), 32'(got.out_green));
      check_field("out_blue", 32'(want.out_blue), 32'(got.out_blue));
      check_field("last_of_run", 32'(want.last_of_run), 32'(got.last_of_run));
    endfunction
  endclass

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  rcf_in_t             in_data_i   = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  rcf_out_t            out_data_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i  = '0;

  int             gap_pct      = 0;
  int             stall_pct    = 0;
  int             quiet_cycles = 0;
  conv_scoreboard sb           = new();

  rgb_3x3_convolution_filter_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  // Predict on every input transfer, check every output transfer, watch for a hang.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sb.take_pixel(in_data_i);
      if (out_valid_o && !out_stall_i) sb.check_result(out_data_o);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QuietLimit) begin
        $display("FAIL rgb_3x3_convolution_filter_core");
        $finish;
      end
    end
  end

  function automatic rcf_in_t pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic fs);
    rcf_in_t p;
    p.in_red      = r;
    p.in_green    = g;
    p.in_blue     = b;
    p.frame_start = fs;
    return p;
  endfunction

  function automatic logic [7:0] rand_chan();
    case ($urandom_range(7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic set_idling(int profile);
    case (profile % 4)
      0: begin
        gap_pct   = 0;
        stall_pct = 0;
      end
      1: begin
        gap_pct   = 47;
        stall_pct = 0;
      end
      2: begin
        gap_pct   = 0;
        stall_pct = 47;
      end
      default: begin
        gap_pct   = 24;
        stall_pct = 24;
      end
    endcase
  endtask

  // Leave cfg_valid_i high across back-to-back writes; the caller drops it.
  task automatic write_reg(cfg_idx_e idx, int unsigned val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val[15:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_reg(idx, val[15:0]);
  endtask

  task automatic send_pixel(rcf_in_t px);
    while ($urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= px;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Wait out all expected results plus any pixel still in flight that makes none.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.expected_px.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic pick_settings();
    int unsigned wv, hv, xs, xe, ys, ye, i;
    int unsigned val [7];
    case ($urandom_range(11))
      0:                wv = 0;
      1:                wv = 1;
      2:                wv = 2;
      3, 4, 5, 6, 7, 8: wv = $urandom_range(9, 3);
      9:                wv = $urandom_range(40, 10);
      default:          wv = $urandom_range(1) ? 4095 : $urandom_range(4095, 41);
    endcase
    case ($urandom_range(11))
      0:                hv = 0;
      1:                hv = 1;
      2:                hv = 2;
      3, 4, 5, 6, 7, 8: hv = $urandom_range(8, 3);
      9:                hv = $urandom_range(30, 9);
      default:          hv = $urandom_range(1) ? 65535 : $urandom_range(65535, 31);
    endcase
    case ($urandom_range(7))
      0: begin
        xs = 0;
        xe = 4095;
        ys = 0;
        ye = 65535;
      end
      1: begin
        xs = $urandom_range(wv + 1);
        xe = $urandom_range(xs);
        ys = $urandom_range(hv + 1);
        ye = $urandom_range(ys);
      end
      2: begin
        xs = $urandom_range(4095, wv);
        xe = 4095;
        ys = 0;
        ye = 65535;
      end
      default: begin
        xs = $urandom_range(wv + 1);
        xe = $urandom_range(wv + 2, xs);
        ys = $urandom_range(hv + 1);
        ye = $urandom_range(hv + 2, ys);
      end
    endcase
    val[CfgMode]   = $urandom_range(3);
    val[CfgWidth]  = wv;
    val[CfgHeight] = hv;
    val[CfgXStart] = xs;
    val[CfgXEnd]   = xe;
    val[CfgYStart] = ys;
    val[CfgYEnd]   = ye;
    for (i = 0; i < 7; i++) begin
      if ($urandom_range(9) < 7) write_reg(cfg_idx_e'(i), val[i]);
    end
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    int unsigned n, w_eff, h_eff, prev_w, rand_px, phase, i;
    logic        fresh, ctr;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Edge kernel on a 3x3 frame: red clamps low, green clamps high, then wrap.
    set_idling(0);
    write_reg(CfgMode, ModeEdge);
    write_reg(CfgWidth, 3);
    write_reg(CfgHeight, 3);
    write_reg(CfgXStart, 0);
    write_reg(CfgXEnd, 4095);
    write_reg(CfgYStart, 0);
    write_reg(CfgYEnd, 65535);
    cfg_valid_i <= 1'b0;
    for (i = 0; i < 11; i++) begin
      ctr = (i == 4);
      if (i < 9) begin
        send_pixel(pixel(ctr ? 8'h00 : 8'hFF, ctr ? 8'hFF : 8'h00, rand_chan(), i == 0));
      end else begin
        send_pixel(pixel(rand_chan(), rand_chan(), rand_chan(), 1'b0));
      end
    end
    drain();

    // Zero width and height act as a 1x1 image.
    set_idling(1);
    write_reg(CfgMode, ModeSharpen);
    write_reg(CfgWidth, 0);
    write_reg(CfgHeight, 0);
    cfg_valid_i <= 1'b0;
    send_pixel(pixel(8'hFF, 8'hFF, 8'hFF, 1'b1));
    send_pixel(pixel(8'h00, 8'h00, 8'h00, 1'b0));
    send_pixel(pixel(8'hFF, 8'h00, 8'hFF, 1'b0));
    send_pixel(pixel(8'h00, 8'hFF, 8'h00, 1'b1));
    drain();

    // Largest Gaussian sums on a saturated 3x3 frame.
    set_idling(2);
    write_reg(CfgMode, ModeGauss);
    write_reg(CfgWidth, 3);
    write_reg(CfgHeight, 3);
    cfg_valid_i <= 1'b0;
    for (i = 0; i < 9; i++) send_pixel(pixel(8'hFF, 8'hFF, 8'hFF, i == 0));
    drain();

    rand_px = 0;
    phase   = 1;
    prev_w  = sb.eff_width();
    while (rand_px < RandomPixels) begin
      set_idling(phase);
      pick_settings();
      w_eff = sb.eff_width();
      h_eff = sb.eff_height();
      if (w_eff * h_eff <= 100) begin
        n = w_eff * h_eff * $urandom_range(2, 1) + $urandom_range(5);
      end else begin
        n = $urandom_range(60, 10);
      end
      // Now and then keep the running frame so counters can sit past a shrunk size;
      // a wider image always starts a new frame.
      fresh  = ($urandom_range(3) != 0) || (w_eff > prev_w);
      prev_w = w_eff;
      for (i = 0; i < n; i++) begin
        send_pixel(pixel(rand_chan(), rand_chan(), rand_chan(),
                         (i == 0) ? fresh : ($urandom_range(49) == 0)));
      end
      drain();
      rand_px += n;
      phase++;
    end

    if (sb.errors == 0) begin
      $display("PASS rgb_3x3_convolution_filter_core");
    end else begin
      $display("FAIL rgb_3x3_convolution_filter_core");
    end
    $finish;
  end

endmodule
